// ===== rtl/core/cbq_pkg.sv =====
// Package for the cascaded biquad filter: word formats, item codes and
// coefficient selectors shared by the channel interfaces and the RTL.
// No dependencies.
package cbq_pkg;

    localparam int WORD_BITS = 40;
    localparam int WORD_FRAC = 8;
    localparam int COEF_BITS = 32;
    localparam int CFG_BITS  = 4;
    localparam int SEC_BITS  = 3;
    localparam int SEL_BITS  = 2;
    localparam int MUL_SPLIT = 16;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef enum logic [SEL_BITS-1:0] {
        COEF_A0 = 2'd0,
        COEF_A1 = 2'd1,
        COEF_B1 = 2'd2,
        COEF_B2 = 2'd3
    } t_coef_sel;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [COEF_BITS-1:0] t_coef;

    typedef struct packed {
        logic  ov;
        t_word val;
    } t_sat;

endpackage

// ===== rtl/core/cbq_in_if.sv =====
// Input channel of the cascaded biquad filter: sample and coefficient items.
// Depends on cbq_pkg.
interface cbq_in_if #(
    parameter int SAMPLE_BITS = 24
);
    import cbq_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [SEC_BITS-1:0]          section_index;
    logic [SEL_BITS-1:0]          coef_select;
    logic signed [COEF_BITS-1:0]  coef_value;

    modport source (
        output valid, kind, sample_in, section_index, coef_select, coef_value,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_in, section_index, coef_select, coef_value,
        output ready
    );
endinterface

// ===== rtl/core/cbq_out_if.sv =====
// Output channel of the cascaded biquad filter: filtered samples and flag.
// No package dependencies.
interface cbq_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          overflow;

    modport source (output valid, sample_out, overflow, input ready);
    modport sink (input valid, sample_out, overflow, output ready);
endinterface

// ===== rtl/core/cbq_cfg_if.sv =====
// Configuration write channel of the cascaded biquad filter.
// Depends on cbq_pkg.
interface cbq_cfg_if;
    import cbq_pkg::*;

    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/cbq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/cascaded_biquad_iir_filter.sv =====
// Cascaded biquad IIR filter, direct form II, coefficients and delays in RAM.
// Coefficient item: written to the coefficient RAM, no result. Sample item: runs
// the n active sections (capped at MAX_SECTIONS, none when n is 0); the result is
// registered when the output is free, next item taken the cycle after. The steps
// of a section suit the shared two-stage multiplier and one coefficient read port.
// Synchronous active-low reset clears control, valid bits and sets n to 1.
module cascaded_biquad_iir_filter #(
    parameter int MAX_SECTIONS   = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbq_in_if.sink    i_in,
    cbq_out_if.source o_out,
    cbq_cfg_if.sink   i_cfg
);
    import cbq_pkg::*;

    localparam int SEC_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_SECTIONS + 1);
    localparam int CDEPTH  = 4 * MAX_SECTIONS;
    localparam int CADDR_W = SEC_W + SEL_BITS;
    localparam int PROD_W  = COEF_BITS + WORD_BITS;
    localparam int WH_W    = WORD_BITS - MUL_SPLIT;
    localparam int SUM_W   = WORD_BITS + 2;
    localparam logic [PROD_W-1:0] MUL_ROUND = PROD_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [WORD_BITS:0] OUT_ROUND =
        (WORD_BITS + 1)'(1) << (WORD_FRAC - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_TAIL, ST_DONE} t_state;
    typedef enum logic [2:0] {PH_LOAD, PH_B1, PH_B2, PH_A1, PH_W, PH_S} t_phase;

    function automatic t_sat sat_word(input logic signed [SUM_W-1:0] v);
        t_sat res;
        if (v > SUM_W'($signed({1'b0, {(WORD_BITS-1){1'b1}}}))) begin
            res.ov  = 1'b1;
            res.val = {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (v < -SUM_W'($signed({1'b0, {(WORD_BITS-1){1'b1}}})) - SUM_W'(1)) begin
            res.ov  = 1'b1;
            res.val = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            res.ov  = 1'b0;
            res.val = v[WORD_BITS-1:0];
        end
        return res;
    endfunction

    t_state              r_state;
    t_phase              r_step;
    logic [SEC_W-1:0]    r_sec;
    logic                r_prev;
    logic [CFG_BITS-1:0] r_active;
    logic                r_ov;
    t_word               r_x, r_w1, r_w2, r_m1, r_w, r_s;
    t_coef               r_a0;
    logic                r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                r_out_ov;

    logic [CDEPTH-1:0]       r_coef_valid;
    logic [MAX_SECTIONS-1:0] r_dly_valid;
    logic                    r_coef_vld_q;
    logic                    r_dly_vld_q;

    logic signed [COEF_BITS+WH_W-1:0]      r_pp_hi;
    logic signed [COEF_BITS+MUL_SPLIT:0]   r_pp_lo;
    t_word                                 r_mres;
    logic                                  r_mov;

    logic [CNT_W-1:0]            n_eff;
    logic                        last_sec;
    logic                        in_acc;
    logic                        out_load;
    logic                        coef_we;
    logic [CADDR_W-1:0]          coef_waddr;
    t_coef_sel                   rd_sel;
    logic [CADDR_W-1:0]          coef_raddr;
    logic [COEF_BITS-1:0]        coef_ram_q;
    t_coef                       coef_q;
    logic                        dly_we;
    logic [2*WORD_BITS-1:0]      dly_ram_q;
    logic [2*WORD_BITS-1:0]      dly_q;
    t_word                       dly_w1, dly_w2;
    t_coef                       mul_c;
    t_word                       mul_w;
    logic signed [PROD_W-1:0]    prod;
    logic [PROD_W-COEF_FRAC_BITS-WORD_BITS:0] prod_hi;
    logic signed [SUM_W-1:0]     sum;
    t_sat                        sum_sat;
    logic signed [WORD_BITS:0]   out_rnd;
    logic [WORD_BITS-WORD_FRAC-SAMPLE_BITS+1:0] out_hi;
    logic signed [SAMPLE_BITS-1:0] out_val;
    logic                        out_ov;

    always_comb begin
        if (32'(r_active) > 32'(MAX_SECTIONS)) begin
            n_eff = CNT_W'(MAX_SECTIONS);
        end else begin
            n_eff = CNT_W'(r_active);
        end
    end

    assign last_sec    = (CNT_W'(r_sec) + CNT_W'(1)) == n_eff;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign coef_we     = in_acc && (i_in.kind == KIND_COEF)
                         && (32'(i_in.section_index) < 32'(MAX_SECTIONS));
    assign coef_waddr  = {SEC_W'(i_in.section_index), i_in.coef_select};

    always_comb begin
        case (r_step)
            PH_LOAD: rd_sel = COEF_B1;
            PH_B1:   rd_sel = COEF_B2;
            PH_B2:   rd_sel = COEF_A1;
            default: rd_sel = COEF_A0;
        endcase
    end
    assign coef_raddr = {r_sec, rd_sel};

    cbq_ram #(.WIDTH(COEF_BITS), .DEPTH(CDEPTH)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_in.coef_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_ram_q)
    );

    assign dly_we = (r_state == ST_RUN) && (r_step == PH_S);

    cbq_ram #(.WIDTH(2 * WORD_BITS), .DEPTH(MAX_SECTIONS)) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (r_sec),
        .i_wdata ({r_w, r_w1}),
        .i_raddr (r_sec),
        .o_rdata (dly_ram_q)
    );

    assign coef_q = r_coef_vld_q ? $signed(coef_ram_q) : '0;
    assign dly_q  = r_dly_vld_q ? dly_ram_q : '0;
    assign dly_w1 = dly_q[2*WORD_BITS-1:WORD_BITS];
    assign dly_w2 = dly_q[WORD_BITS-1:0];

    always_comb begin
        case (r_step)
            PH_B1: begin
                mul_c = coef_q;
                mul_w = dly_w1;
            end
            PH_B2: begin
                mul_c = coef_q;
                mul_w = r_w2;
            end
            PH_A1: begin
                mul_c = coef_q;
                mul_w = r_w1;
            end
            default: begin
                mul_c = r_a0;
                mul_w = r_s;
            end
        endcase
    end

    assign prod    = $signed((PROD_W'(r_pp_hi) << MUL_SPLIT) + PROD_W'(r_pp_lo) + MUL_ROUND);
    assign prod_hi = prod[PROD_W-1:COEF_FRAC_BITS+WORD_BITS-1];

    always_ff @(posedge i_clk) begin
        r_pp_hi <= mul_c * $signed(mul_w[WORD_BITS-1:MUL_SPLIT]);
        r_pp_lo <= mul_c * $signed({1'b0, mul_w[MUL_SPLIT-1:0]});
        if ((&prod_hi) || !(|prod_hi)) begin
            r_mov  <= 1'b0;
            r_mres <= prod[COEF_FRAC_BITS+WORD_BITS-1:COEF_FRAC_BITS];
        end else begin
            r_mov  <= 1'b1;
            r_mres <= prod[PROD_W-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                     : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    always_comb begin
        if (r_step == PH_W) begin
            sum = SUM_W'(r_x) - SUM_W'(r_m1) - SUM_W'(r_mres);
        end else begin
            sum = SUM_W'(r_w) + SUM_W'(r_mres) + SUM_W'(r_w2);
        end
        sum_sat = sat_word(sum);
    end

    assign out_rnd = (WORD_BITS + 1)'(r_x) + OUT_ROUND;
    assign out_hi  = out_rnd[WORD_BITS:WORD_FRAC+SAMPLE_BITS-1];

    always_comb begin
        if ((&out_hi) || !(|out_hi)) begin
            out_ov  = 1'b0;
            out_val = out_rnd[WORD_FRAC+SAMPLE_BITS-1:WORD_FRAC];
        end else begin
            out_ov  = 1'b1;
            out_val = out_rnd[WORD_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.overflow   = r_out_ov;

    always_ff @(posedge i_clk) begin
        r_coef_vld_q <= r_coef_valid[coef_raddr];
        r_dly_vld_q  <= r_dly_valid[r_sec];
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= PH_LOAD;
            r_sec        <= '0;
            r_prev       <= 1'b0;
            r_active     <= CFG_BITS'(1);
            r_out_valid  <= 1'b0;
            r_coef_valid <= '0;
            r_dly_valid  <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_active <= i_cfg.data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (coef_we) begin
                r_coef_valid[coef_waddr] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.kind == KIND_SAMPLE)) begin
                        r_x    <= WORD_BITS'(i_in.sample_in) <<< WORD_FRAC;
                        r_ov   <= 1'b0;
                        r_sec  <= '0;
                        r_step <= PH_LOAD;
                        r_prev <= 1'b0;
                        r_state <= (n_eff == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    case (r_step)
                        PH_LOAD: begin
                            r_step <= PH_B1;
                        end
                        PH_B1: begin
                            r_w1   <= dly_w1;
                            r_w2   <= dly_w2;
                            r_step <= PH_B2;
                        end
                        PH_B2: begin
                            if (r_prev) begin
                                r_x  <= r_mres;
                                r_ov <= r_ov | r_mov;
                            end
                            r_step <= PH_A1;
                        end
                        PH_A1: begin
                            r_m1   <= r_mres;
                            r_ov   <= r_ov | r_mov;
                            r_step <= PH_W;
                        end
                        PH_W: begin
                            r_a0   <= coef_q;
                            r_w    <= sum_sat.val;
                            r_ov   <= r_ov | r_mov | sum_sat.ov;
                            r_step <= PH_S;
                        end
                        PH_S: begin
                            r_s    <= sum_sat.val;
                            r_ov   <= r_ov | r_mov | sum_sat.ov;
                            r_dly_valid[r_sec] <= 1'b1;
                            r_prev <= 1'b1;
                            r_step <= PH_LOAD;
                            if (last_sec) begin
                                r_state <= ST_TAIL;
                            end else begin
                                r_sec <= r_sec + SEC_W'(1);
                            end
                        end
                        default: begin
                            r_step <= PH_LOAD;
                        end
                    endcase
                end
                ST_TAIL: begin
                    case (r_step)
                        PH_LOAD: r_step <= PH_B1;
                        PH_B1:   r_step <= PH_B2;
                        default: begin
                            r_x     <= r_mres;
                            r_ov    <= r_ov | r_mov;
                            r_step  <= PH_LOAD;
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out_sample <= out_val;
                        r_out_ov     <= r_ov | out_ov;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== dv/tb_cascaded_biquad_iir_filter.sv =====
// Self-checking testbench for the cascaded biquad IIR filter: directed and random
// sample and coefficient items, checked against a fixed-point predictor.
// Depends on cbq_pkg, cbq_in_if, cbq_out_if, cbq_cfg_if and cascaded_biquad_iir_filter.
`timescale 1ns / 100ps

module tb_cascaded_biquad_iir_filter;
    import cbq_pkg::*;

    localparam int MAX_SECTIONS   = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 24;
    localparam int SETTLE_CYCLES  = 60;
    localparam int DRAIN_GUARD    = 20000;
    localparam int MAX_IDLE       = 18;
    localparam int RANDOM_PHASES  = 10;
    localparam longint TIMEOUT_NS = 5_000_000;

    localparam logic signed [79:0] WORD_HI    = 80'sh7F_FFFF_FFFF;
    localparam logic signed [79:0] WORD_LO    = -WORD_HI - 80'sd1;
    localparam logic signed [79:0] SAMPLE_HI  = 80'sd8388607;
    localparam logic signed [79:0] SAMPLE_LO  = -80'sd8388608;
    localparam logic signed [79:0] COEF_ROUND = 80'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [79:0] OUT_ROUND  = 80'sd1 <<< (WORD_FRAC - 1);

    localparam t_coef ONE_Q24       = 32'sh0100_0000;
    localparam t_coef TWO_Q24       = 32'sh0200_0000;
    localparam t_coef MINUS_1P5_Q24 = -32'sd25165824;
    localparam t_coef B2_DIRECTED   = 32'sd9437184;
    localparam t_coef COEF_MAX      = 32'sh7FFF_FFFF;
    localparam t_coef COEF_MIN      = 32'sh8000_0000;

    typedef struct {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [SEC_BITS-1:0]           section;
        t_coef_sel                     sel;
        t_coef                         value;
    } t_biquad_item;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          ov;
    } t_filt_result;

    logic i_clk;
    logic i_rst_n;

    cbq_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_bus ();
    cbq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_bus ();
    cbq_cfg_if cfg_bus ();

    cascaded_biquad_iir_filter #(
        .MAX_SECTIONS  (MAX_SECTIONS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus),
        .i_cfg  (cfg_bus)
    );

    t_coef              coef_mem [MAX_SECTIONS][4];
    t_word              w1_mem   [MAX_SECTIONS];
    t_word              w2_mem   [MAX_SECTIONS];
    logic [CFG_BITS-1:0] active_n;
    t_filt_result       pending_outputs [$];
    int                 mismatches;
    bit                 in_burst;
    bit                 out_burst;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_sat clip_word(input logic signed [79:0] v);
        t_sat r;
        r.ov  = 1'b0;
        r.val = v[WORD_BITS-1:0];
        if (v > WORD_HI) begin
            r.ov  = 1'b1;
            r.val = WORD_HI[WORD_BITS-1:0];
        end else if (v < WORD_LO) begin
            r.ov  = 1'b1;
            r.val = WORD_LO[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_sat coef_product(input t_coef c, input t_word w);
        logic signed [79:0] cx;
        logic signed [79:0] wx;
        logic signed [79:0] p;
        cx = 80'(c);
        wx = 80'(w);
        p = (cx * wx + COEF_ROUND) >>> COEF_FRAC_BITS;
        return clip_word(p);
    endfunction

    function automatic t_filt_result filter_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        t_filt_result       res;
        t_sat               fb1, fb2, w_new, fwd, brk, y;
        logic signed [79:0] acc;
        t_word              x;
        t_word              w1, w2;
        int                 n;
        logic               ov;
        ov  = 1'b0;
        n   = (active_n > MAX_SECTIONS) ? MAX_SECTIONS : int'(active_n);
        acc = 80'(smp);
        acc = acc <<< WORD_FRAC;
        x   = acc[WORD_BITS-1:0];
        for (int k = 0; k < n; k++) begin
            w1    = w1_mem[k];
            w2    = w2_mem[k];
            fb1   = coef_product(coef_mem[k][COEF_B1], w1);
            fb2   = coef_product(coef_mem[k][COEF_B2], w2);
            acc   = 80'(x);
            acc   = acc - $signed(fb1.val) - $signed(fb2.val);
            w_new = clip_word(acc);
            fwd   = coef_product(coef_mem[k][COEF_A1], w1);
            acc   = 80'($signed(w_new.val));
            acc   = acc + $signed(fwd.val) + w2;
            brk   = clip_word(acc);
            y     = coef_product(coef_mem[k][COEF_A0], brk.val);
            ov    = ov | fb1.ov | fb2.ov | w_new.ov | fwd.ov | brk.ov | y.ov;
            w2_mem[k] = w1;
            w1_mem[k] = w_new.val;
            x = y.val;
        end
        acc = 80'(x);
        acc = (acc + OUT_ROUND) >>> WORD_FRAC;
        if (acc > SAMPLE_HI) begin
            ov  = 1'b1;
            acc = SAMPLE_HI;
        end else if (acc < SAMPLE_LO) begin
            ov  = 1'b1;
            acc = SAMPLE_LO;
        end
        res.sample = acc[SAMPLE_BITS-1:0];
        res.ov     = ov;
        return res;
    endfunction

    function automatic void apply_item(input t_biquad_item it);
        if (it.kind == KIND_COEF) begin
            if (it.section < MAX_SECTIONS) begin
                coef_mem[it.section][it.sel] = it.value;
            end
        end else begin
            pending_outputs.push_back(filter_sample(it.sample));
        end
    endfunction

    function automatic t_biquad_item make_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        t_biquad_item it;
        it.kind    = KIND_SAMPLE;
        it.sample  = smp;
        it.section = SEC_BITS'($urandom_range(0, 7));
        it.sel     = t_coef_sel'($urandom_range(0, 3));
        it.value   = $urandom;
        return it;
    endfunction

    function automatic t_biquad_item make_coef(input logic [SEC_BITS-1:0] sec,
                                               input t_coef_sel sel, input t_coef value);
        t_biquad_item it;
        it.kind    = KIND_COEF;
        it.sample  = SAMPLE_BITS'($urandom);
        it.section = sec;
        it.sel     = sel;
        it.value   = value;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return SAMPLE_BITS'($urandom);
        end else if (roll < 90) begin
            return SAMPLE_BITS'($urandom_range(0, 4096) - 2048);
        end else begin
            case ($urandom_range(0, 2))
                0: return SAMPLE_HI[SAMPLE_BITS-1:0];
                1: return SAMPLE_LO[SAMPLE_BITS-1:0];
                default: return '0;
            endcase
        end
    endfunction

    task automatic send_item(input t_biquad_item it);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.kind          <= it.kind;
        in_bus.sample_in     <= it.sample;
        in_bus.section_index <= it.section;
        in_bus.coef_select   <= it.sel;
        in_bus.coef_value    <= it.value;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        apply_item(it);
    endtask

    task automatic drain_outputs(input int tail);
        int guard;
        guard = 0;
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_outputs.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_sections(input logic [CFG_BITS-1:0] n);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= n;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        active_n = n;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic program_stable_cascade();
        int b2, lim, b1, a0, a1;
        for (int sec = 0; sec < MAX_SECTIONS; sec++) begin
            b2  = $urandom_range(0, 2 * 15099494) - 15099494;
            lim = (((1 << 24) + b2) / 100) * 95;
            b1  = $urandom_range(0, 2 * lim) - lim;
            a0  = $urandom_range(0, 1 << 25) - (1 << 24);
            a1  = $urandom_range(0, 1 << 26) - (1 << 25);
            send_item(make_coef(SEC_BITS'(sec), COEF_A0, a0));
            send_item(make_coef(SEC_BITS'(sec), COEF_A1, a1));
            send_item(make_coef(SEC_BITS'(sec), COEF_B1, b1));
            send_item(make_coef(SEC_BITS'(sec), COEF_B2, b2));
        end
    endtask

    task automatic test_pass_through();
        write_sections(4'd0);
        send_item(make_sample('0));
        send_item(make_sample(SAMPLE_HI[SAMPLE_BITS-1:0]));
        send_item(make_sample(SAMPLE_LO[SAMPLE_BITS-1:0]));
        send_item(make_sample(SAMPLE_BITS'(-1)));
        send_item(make_sample(SAMPLE_BITS'(1)));
    endtask

    task automatic test_single_section();
        drain_outputs(SETTLE_CYCLES);
        write_sections(4'd1);
        send_item(make_coef(SEC_BITS'(0), COEF_A0, ONE_Q24));
        send_item(make_coef(SEC_BITS'(0), COEF_A1, TWO_Q24));
        send_item(make_coef(SEC_BITS'(0), COEF_B1, MINUS_1P5_Q24));
        send_item(make_coef(SEC_BITS'(0), COEF_B2, B2_DIRECTED));
        send_item(make_sample(SAMPLE_HI[SAMPLE_BITS-1:0]));
        send_item(make_sample(SAMPLE_LO[SAMPLE_BITS-1:0]));
        send_item(make_sample('0));
        send_item(make_sample(SAMPLE_BITS'(1)));
        send_item(make_coef(SEC_BITS'(0), COEF_A0, COEF_MAX));
        send_item(make_sample(SAMPLE_HI[SAMPLE_BITS-1:0]));
        send_item(make_coef(SEC_BITS'(0), COEF_A0, COEF_MIN));
        send_item(make_sample(SAMPLE_BITS'(-1)));
    endtask

    task automatic test_section_cap();
        drain_outputs(SETTLE_CYCLES);
        write_sections(4'd15);
        send_item(make_sample(SAMPLE_HI[SAMPLE_BITS-1:0]));
        send_item(make_sample(SAMPLE_BITS'(-1000)));
        drain_outputs(SETTLE_CYCLES);
        write_sections(4'd8);
        send_item(make_sample(SAMPLE_BITS'(12345)));
    endtask

    task automatic test_random_traffic();
        int n_items;
        int roll;
        logic [CFG_BITS-1:0] n_sec;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_outputs(SETTLE_CYCLES);
            n_sec = (ph == 0) ? 4'd8 : (ph == 1) ? 4'd1 : 4'($urandom_range(0, 15));
            write_sections(n_sec);
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) begin
                program_stable_cascade();
            end
            n_items = $urandom_range(40, 60);
            for (int i = 0; i < n_items; i++) begin
                if ((ph == 0 && i == 20) || $urandom_range(0, 59) == 0) begin
                    drain_outputs(0);
                end
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    send_item(make_coef(SEC_BITS'($urandom_range(0, 7)),
                                        t_coef_sel'($urandom_range(0, 3)), $urandom));
                end else if (roll < 15) begin
                    send_item(make_coef(SEC_BITS'($urandom_range(0, 7)),
                                        t_coef_sel'($urandom_range(0, 3)),
                                        $urandom_range(0, 1 << 26) - (1 << 25)));
                end else begin
                    send_item(make_sample(random_sample()));
                end
            end
        end
    endtask

    initial begin
        int stall;
        t_filt_result want;
        out_bus.ready = 1'b0;
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
            @(negedge i_clk);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_bus.valid && i_rst_n)) @(posedge i_clk);
            if (pending_outputs.size() == 0) begin
                $error("unexpected result: sample_out %0d overflow %0b",
                       out_bus.sample_out, out_bus.overflow);
                mismatches++;
            end else begin
                want = pending_outputs.pop_front();
                if (out_bus.sample_out !== want.sample) begin
                    $error("sample_out: expected %0d, actual %0d", want.sample,
                           out_bus.sample_out);
                    mismatches++;
                end
                if (out_bus.overflow !== want.ov) begin
                    $error("overflow: expected %0b, actual %0b", want.ov, out_bus.overflow);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL cascaded_biquad_iir_filter");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.kind          = KIND_SAMPLE;
        in_bus.sample_in     = '0;
        in_bus.section_index = '0;
        in_bus.coef_select   = COEF_A0;
        in_bus.coef_value    = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.data         = '0;
        mismatches           = 0;
        in_burst             = 1'b0;
        out_burst            = 1'b0;
        active_n             = 4'd1;
        for (int k = 0; k < MAX_SECTIONS; k++) begin
            w1_mem[k] = '0;
            w2_mem[k] = '0;
            for (int c = 0; c < 4; c++) begin
                coef_mem[k][c] = '0;
            end
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_pass_through();
        test_single_section();
        test_section_cap();
        test_random_traffic();

        drain_outputs(SETTLE_CYCLES);
        if (pending_outputs.size() != 0) begin
            $error("%0d expected results never arrived", pending_outputs.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASS cascaded_biquad_iir_filter");
        end else begin
            $display("FAIL cascaded_biquad_iir_filter");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cbq_pkg.sv
rtl/core/cbq_in_if.sv
rtl/core/cbq_out_if.sv
rtl/core/cbq_cfg_if.sv
rtl/core/cbq_ram.sv
rtl/core/cascaded_biquad_iir_filter.sv
dv/tb_cascaded_biquad_iir_filter.sv
